>>> rtl/core/swk_pkg.sv
`timescale 1ns / 1ps

package swk_pkg;

  localparam int TW  = 31;
  localparam int AW  = 15;
  localparam int SW  = 60;
  localparam int RW  = 30;
  localparam int NQ  = 30;
  localparam int XW  = 34;
  localparam int ZW  = 25;
  localparam int NW  = 50;
  localparam int QW  = 20;
  localparam int LW  = 24;
  localparam int AGW = 16;
  localparam int SPW = 13;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  typedef enum logic [1:0] {
    REG_WHEEL_BASE  = 2'd0,
    REG_WHEEL_TRACK = 2'd1,
    REG_MAX_SPEED   = 2'd2
  } reg_idx_e;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(1152000);
      1:  v = ZW'(680065);
      2:  v = ZW'(359328);
      3:  v = ZW'(182400);
      4:  v = ZW'(91554);
      5:  v = ZW'(45822);
      6:  v = ZW'(22916);
      7:  v = ZW'(11459);
      8:  v = ZW'(5730);
      9:  v = ZW'(2865);
      10: v = ZW'(1432);
      11: v = ZW'(716);
      12: v = ZW'(358);
      13: v = ZW'(179);
      14: v = ZW'(90);
      15: v = ZW'(45);
      16: v = ZW'(22);
      17: v = ZW'(11);
      18: v = ZW'(6);
      19: v = ZW'(3);
      20: v = ZW'(1);
      21: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/swerve_wheel_kinematics_top.sv
`timescale 1ns / 1ps

// Four-wheel swerve inverse kinematics. One chassis command is taken per clock while
// the output is not stalled. Its four wheel angles and speeds are registered at the outputs.
// The pipeline depth is set by the 30-step square root pipeline (which also carries
// the CORDIC stages) and the 20-step pipelined divider for speed normalization.
// A stalled output freezes the whole pipeline. A write to the speed limit reaches the
// overflow check once the limit product and then the speed limit square have been
// re-registered.
module swerve_wheel_kinematics_top #(
  parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [13:0]               forward_speed_i,
  input  logic signed [13:0]               strafe_speed_i,
  input  logic signed [15:0]               turn_rate_i,
  input  logic signed [11:0]               rot_center_x_i,
  input  logic signed [11:0]               rot_center_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [swk_pkg::AGW-1:0]   front_left_angle_o,
  output logic [swk_pkg::SPW-1:0]          front_left_speed_o,
  output logic signed [swk_pkg::AGW-1:0]   front_right_angle_o,
  output logic [swk_pkg::SPW-1:0]          front_right_speed_o,
  output logic signed [swk_pkg::AGW-1:0]   back_left_angle_o,
  output logic [swk_pkg::SPW-1:0]          back_left_speed_o,
  output logic signed [swk_pkg::AGW-1:0]   back_right_angle_o,
  output logic [swk_pkg::SPW-1:0]          back_right_speed_o
);

  localparam int TW  = swk_pkg::TW;
  localparam int AW  = swk_pkg::AW;
  localparam int SW  = swk_pkg::SW;
  localparam int RW  = swk_pkg::RW;
  localparam int NQ  = swk_pkg::NQ;
  localparam int XW  = swk_pkg::XW;
  localparam int ZW  = swk_pkg::ZW;
  localparam int NW  = swk_pkg::NW;
  localparam int QW  = swk_pkg::QW;
  localparam int LW  = swk_pkg::LW;
  localparam int AGW = swk_pkg::AGW;
  localparam int SPW = swk_pkg::SPW;

  localparam int L_LOOP = 6;
  localparam int L_MAX  = L_LOOP + NQ;
  localparam int L_DIV  = L_MAX + 2;
  localparam int NS     = L_DIV + QW + 1;

  localparam int WHEEL_Y [4] = '{1, 1, 0, 0};
  localparam int WHEEL_X [4] = '{3, 2, 3, 2};

  localparam logic signed [TW-1:0] K2000    = TW'(2000);
  localparam logic signed [ZW-1:0] QUARTER  = ZW'(2304000);
  localparam logic signed [ZW-1:0] ANG_MAX  = ZW'(18000);
  localparam logic signed [ZW-1:0] ANG_MIN  = -ZW'(18000);
  localparam logic signed [ZW-1:0] ANG_RND  = ZW'(128);
  localparam logic [SPW-1:0]       SPD_MAX  = '1;
  localparam logic [QW-1:0]        SPD_LIM  = QW'(8191);

  // configuration
  logic [11:0]   wheel_base_q, wheel_track_q;
  logic [12:0]   max_wheel_speed_q;
  logic [LW-1:0] klim_q;
  logic [2*LW-1:0] lim_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_base_q      <= 12'd600;
      wheel_track_q     <= 12'd600;
      max_wheel_speed_q <= 13'd4500;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        swk_pkg::REG_WHEEL_BASE:  wheel_base_q      <= pwdata[11:0];
        swk_pkg::REG_WHEEL_TRACK: wheel_track_q     <= pwdata[11:0];
        swk_pkg::REG_MAX_SPEED:   max_wheel_speed_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      swk_pkg::REG_WHEEL_BASE:  prdata = {20'd0, wheel_base_q};
      swk_pkg::REG_WHEEL_TRACK: prdata = {20'd0, wheel_track_q};
      swk_pkg::REG_MAX_SPEED:   prdata = {19'd0, max_wheel_speed_q};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    klim_q <= LW'(max_wheel_speed_q) * LW'(2000);
    lim_q  <= (2*LW)'(klim_q) * (2*LW)'(klim_q);
  end

  // pipeline control
  logic          en;
  logic [NS-1:0] v_q;

  assign en         = !(v_q[NS-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // stage 0..5
  logic signed [13:0]   fwd_q, str_q;
  logic signed [15:0]   tr_q, tr1_q;
  logic signed [11:0]   rcx_q, rcy_q;
  logic signed [TW-1:0] vx1_q, vy1_q, vx2_q, vy2_q, ol_q, ow_q;
  logic signed [AW-1:0] arml_q, armw_q;
  logic signed [TW-1:0] term_q [4];
  logic signed [TW-1:0] term4_q [4];
  logic [SW-1:0]        sq_q [4];
  logic [SW-1:0]        sum_q [4];
  logic signed [XW-1:0] cx_q [4], cy_q [4];
  logic signed [ZW-1:0] cz_q [4];
  logic [3:0]           czero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_q  <= forward_speed_i;
      str_q  <= strafe_speed_i;
      tr_q   <= turn_rate_i;
      rcx_q  <= rot_center_x_i;
      rcy_q  <= rot_center_y_i;
      vx1_q  <= -(TW'(str_q) * K2000);
      vy1_q  <= TW'(fwd_q) * K2000;
      arml_q <= $signed({3'b000, wheel_base_q}) - (AW'(rcx_q) <<< 1);
      armw_q <= $signed({3'b000, wheel_track_q}) - (AW'(rcy_q) <<< 1);
      tr1_q  <= tr_q;
      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
      ol_q   <= TW'(tr1_q) * TW'(arml_q);
      ow_q   <= TW'(tr1_q) * TW'(armw_q);
      term_q[0] <= vx2_q - ol_q;
      term_q[1] <= vx2_q + ol_q;
      term_q[2] <= vy2_q - ow_q;
      term_q[3] <= vy2_q + ow_q;
    end
  end

  logic [RW-1:0]        tabs [4];
  logic [SW-1:0]        sum_d [4];
  logic signed [XW-1:0] cx_d [4], cy_d [4];
  logic signed [ZW-1:0] cz_d [4];
  logic [3:0]           czero_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tabs[k] = term_q[k][TW-1] ? RW'(-term_q[k]) : RW'(term_q[k]);
    end
  end

  always_comb begin
    logic signed [TW-1:0] yi, xi;
    for (int k = 0; k < 4; k++) begin
      yi = term4_q[WHEEL_Y[k]];
      xi = term4_q[WHEEL_X[k]];
      sum_d[k]   = sq_q[WHEEL_Y[k]] + sq_q[WHEEL_X[k]];
      czero_d[k] = (xi == '0) && (yi == '0);
      if (xi[TW-1]) begin
        if (!yi[TW-1]) begin
          cx_d[k] = XW'(yi);
          cy_d[k] = -XW'(xi);
          cz_d[k] = QUARTER;
        end else begin
          cx_d[k] = -XW'(yi);
          cy_d[k] = XW'(xi);
          cz_d[k] = -QUARTER;
        end
      end else begin
        cx_d[k] = XW'(xi);
        cy_d[k] = XW'(yi);
        cz_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sq_q[k]    <= SW'(tabs[k]) * SW'(tabs[k]);
        term4_q[k] <= term_q[k];
        sum_q[k]   <= sum_d[k];
        cx_q[k]    <= cx_d[k];
        cy_q[k]    <= cy_d[k];
        cz_q[k]    <= cz_d[k];
      end
      czero_q <= czero_d;
    end
  end

  // square root and CORDIC stages
  logic [SW-1:0]        lrem_q  [NQ][4];
  logic [SW-1:0]        lroot_q [NQ][4];
  logic signed [XW-1:0] lx_q [NQ][4], ly_q [NQ][4];
  logic signed [ZW-1:0] lz_q [NQ][4];
  logic [3:0]           lzero_q [NQ];
  logic                 lover_q [NQ];

  for (genvar j = 0; j < NQ; j++) begin : g_loop
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NQ - 1 - j));
    localparam logic signed [ZW-1:0] ATAN = swk_pkg::atan_entry(j);
    localparam bit ACT = (j < CORDIC_STAGES);

    logic [SW-1:0]        rem_s [4], root_s [4], rem_d [4], root_d [4];
    logic signed [XW-1:0] x_s [4], y_s [4], x_d [4], y_d [4];
    logic signed [ZW-1:0] z_s [4], z_d [4];
    logic [3:0]           zero_s;
    logic                 over_s;

    if (j == 0) begin : g_src
      always_comb begin
        over_s = 1'b0;
        for (int k = 0; k < 4; k++) begin
          rem_s[k]  = sum_q[k];
          root_s[k] = '0;
          x_s[k]    = cx_q[k];
          y_s[k]    = cy_q[k];
          z_s[k]    = cz_q[k];
          over_s    = over_s || (sum_q[k] > SW'(lim_q));
        end
        zero_s = czero_q;
      end
    end else begin : g_src
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          rem_s[k]  = lrem_q[j-1][k];
          root_s[k] = lroot_q[j-1][k];
          x_s[k]    = lx_q[j-1][k];
          y_s[k]    = ly_q[j-1][k];
          z_s[k]    = lz_q[j-1][k];
        end
        zero_s = lzero_q[j-1];
        over_s = lover_q[j-1];
      end
    end

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        if (rem_s[k] >= root_s[k] + BIT) begin
          rem_d[k]  = rem_s[k] - (root_s[k] + BIT);
          root_d[k] = (root_s[k] >> 1) + BIT;
        end else begin
          rem_d[k]  = rem_s[k];
          root_d[k] = root_s[k] >> 1;
        end
        if (!ACT) begin
          x_d[k] = x_s[k];
          y_d[k] = y_s[k];
          z_d[k] = z_s[k];
        end else if (!y_s[k][XW-1]) begin
          x_d[k] = x_s[k] + (y_s[k] >>> j);
          y_d[k] = y_s[k] - (x_s[k] >>> j);
          z_d[k] = z_s[k] + ATAN;
        end else begin
          x_d[k] = x_s[k] - (y_s[k] >>> j);
          y_d[k] = y_s[k] + (x_s[k] >>> j);
          z_d[k] = z_s[k] - ATAN;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 4; k++) begin
          lrem_q[j][k]  <= rem_d[k];
          lroot_q[j][k] <= root_d[k];
          lx_q[j][k]    <= x_d[k];
          ly_q[j][k]    <= y_d[k];
          lz_q[j][k]    <= z_d[k];
        end
        lzero_q[j] <= zero_s;
        lover_q[j] <= over_s;
      end
    end
  end

  // maximum, angle rounding
  logic [RW-1:0]         m_d [4], m_q [4], mmax_d, mmax_q, a01, a23;
  logic signed [AGW-1:0] ang_d [4], ang_q [4];
  logic                  over_q;

  always_comb begin
    logic signed [ZW-1:0] h;
    for (int k = 0; k < 4; k++) begin
      m_d[k] = lroot_q[NQ-1][k][RW-1:0];
      h = -((lz_q[NQ-1][k] + ANG_RND) >>> 8);
      if (lzero_q[NQ-1][k])  ang_d[k] = '0;
      else if (h > ANG_MAX)  ang_d[k] = AGW'(ANG_MAX);
      else if (h < ANG_MIN)  ang_d[k] = AGW'(ANG_MIN);
      else                   ang_d[k] = AGW'(h);
    end
    a01    = (m_d[0] > m_d[1]) ? m_d[0] : m_d[1];
    a23    = (m_d[2] > m_d[3]) ? m_d[2] : m_d[3];
    mmax_d = (a01 > a23) ? a01 : a23;
  end

  // numerator and divisor
  logic [NW-1:0]         num_q [4];
  logic [RW-1:0]         den_q;
  logic signed [AGW-1:0] ang2_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= m_d;
      mmax_q <= mmax_d;
      ang_q  <= ang_d;
      over_q <= lover_q[NQ-1];
      for (int k = 0; k < 4; k++) begin
        num_q[k] <= over_q ? NW'(m_q[k]) * NW'(max_wheel_speed_q) + NW'(mmax_q >> 1)
                           : NW'(m_q[k]) + NW'(1000);
      end
      den_q  <= over_q ? mmax_q : RW'(2000);
      ang2_q <= ang_q;
    end
  end

  // restoring divider
  logic [NW-1:0]         drem_q [QW][4];
  logic [QW-1:0]         dquo_q [QW][4];
  logic [RW-1:0]         dden_q [QW];
  logic signed [AGW-1:0] dang_q [QW][4];

  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int B = QW - 1 - i;

    logic [NW-1:0]         rem_s [4], rem_d [4], dsh;
    logic [QW-1:0]         quo_s [4], quo_d [4];
    logic [RW-1:0]         den_s;
    logic signed [AGW-1:0] ang_s [4];

    if (i == 0) begin : g_src
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          rem_s[k] = num_q[k];
          quo_s[k] = '0;
          ang_s[k] = ang2_q[k];
        end
        den_s = den_q;
      end
    end else begin : g_src
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          rem_s[k] = drem_q[i-1][k];
          quo_s[k] = dquo_q[i-1][k];
          ang_s[k] = dang_q[i-1][k];
        end
        den_s = dden_q[i-1];
      end
    end

    always_comb begin
      dsh = NW'(den_s) << B;
      for (int k = 0; k < 4; k++) begin
        quo_d[k] = quo_s[k];
        if (rem_s[k] >= dsh) begin
          rem_d[k]    = rem_s[k] - dsh;
          quo_d[k][B] = 1'b1;
        end else begin
          rem_d[k] = rem_s[k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[i] <= rem_d;
        dquo_q[i] <= quo_d;
        dang_q[i] <= ang_s;
        dden_q[i] <= den_s;
      end
    end
  end

  // output register
  logic [SPW-1:0]        spd_q [4];
  logic signed [AGW-1:0] oang_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        spd_q[k]  <= (dquo_q[QW-1][k] > SPD_LIM) ? SPD_MAX : dquo_q[QW-1][k][SPW-1:0];
        oang_q[k] <= dang_q[QW-1][k];
      end
    end
  end

  assign out_valid_o         = v_q[NS-1];
  assign front_left_angle_o  = oang_q[0];
  assign front_left_speed_o  = spd_q[0];
  assign front_right_angle_o = oang_q[1];
  assign front_right_speed_o = spd_q[1];
  assign back_left_angle_o   = oang_q[2];
  assign back_left_speed_o   = spd_q[2];
  assign back_right_angle_o  = oang_q[3];
  assign back_right_speed_o  = spd_q[3];

  a_speed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (front_left_speed_o <= max_wheel_speed_q)
                 && (front_right_speed_o <= max_wheel_speed_q)
                 && (back_left_speed_o <= max_wheel_speed_q)
                 && (back_right_speed_o <= max_wheel_speed_q))
    else $error("wheel speed above limit");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (front_left_angle_o >= -16'sd18000) && (front_left_angle_o <= 16'sd18000)
                 && (back_right_angle_o >= -16'sd18000) && (back_right_angle_o <= 16'sd18000))
    else $error("steering angle out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(v_q))
    else $error("pipeline moved during output stall");

endmodule

>>> tb/tb_swerve_wheel_kinematics_top.sv
`timescale 1ns / 1ps

module tb_swerve_wheel_kinematics_top;

  localparam int            STAGES      = swk_pkg::CORDIC_STAGES_DEF;
  localparam int            DRAIN_WAIT  = 80;
  localparam logic [3:0]    ADDR_UNUSED = 4'hC;
  localparam longint        ATAN_TAB [24] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

  typedef struct {
    logic signed [15:0] ang [4];
    logic [12:0]        spd [4];
  } wheel_state_t;

  typedef struct {
    logic signed [13:0] fwd;
    logic signed [13:0] str;
    logic signed [15:0] turn;
    logic signed [11:0] rcx;
    logic signed [11:0] rcy;
    bit                 typed;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [13:0] forward_speed_i = '0, strafe_speed_i = '0;
  logic signed [15:0] turn_rate_i = '0;
  logic signed [11:0] rot_center_x_i = '0, rot_center_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] front_left_angle_o, front_right_angle_o;
  logic signed [15:0] back_left_angle_o, back_right_angle_o;
  logic [12:0] front_left_speed_o, front_right_speed_o;
  logic [12:0] back_left_speed_o, back_right_speed_o;

  logic [11:0] cfg_base = 12'd600, cfg_track = 12'd600;
  logic [12:0] cfg_max = 13'd4500;
  wheel_state_t pending_wheels [$];
  int errors = 0;
  int sent = 0, checked = 0, limited = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  swerve_wheel_kinematics_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_sq(longint v);
    longint unsigned a;
    a = (v < 0) ? longint'(-v) : longint'(v);
    return a * a;
  endfunction

  function automatic logic signed [15:0] steer_angle(longint y, longint x);
    longint z, t, dx, dy, h;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 9000 * 256;
      end else begin
        x = -y; y = t; z = -9000 * 256;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += ATAN_TAB[i];
      end else begin
        x -= dy; y += dx; z -= ATAN_TAB[i];
      end
    end
    h = -((z + 128) >>> 8);
    if (h > 18000) h = 18000;
    if (h < -18000) h = -18000;
    return h[15:0];
  endfunction

  function automatic wheel_state_t wheel_states(cmd_row_t c);
    longint vx, vy, ol, ow, ta, tb, tc, td;
    longint ys [4], xs [4];
    longint unsigned s [4], m [4], smax, mmax, lim, sp;
    wheel_state_t r;
    vx = -2000 * longint'(c.str);
    vy = 2000 * longint'(c.fwd);
    ol = longint'(c.turn) * (longint'(cfg_base) - 2 * longint'(c.rcx));
    ow = longint'(c.turn) * (longint'(cfg_track) - 2 * longint'(c.rcy));
    ta = vx - ol; tb = vx + ol; tc = vy - ow; td = vy + ow;
    ys = '{tb, tb, ta, ta};
    xs = '{td, tc, td, tc};
    smax = 0; mmax = 0;
    for (int k = 0; k < 4; k++) begin
      s[k] = mag_sq(ys[k]) + mag_sq(xs[k]);
      m[k] = int_sqrt(s[k]);
      if (s[k] > smax) smax = s[k];
      if (m[k] > mmax) mmax = m[k];
    end
    lim = 64'd2000 * cfg_max;
    lim = lim * lim;
    for (int k = 0; k < 4; k++) begin
      if (smax > lim && mmax != 0) sp = (m[k] * cfg_max + mmax / 2) / mmax;
      else sp = (m[k] + 1000) / 2000;
      if (sp > 8191) sp = 8191;
      r.spd[k] = sp[12:0];
      r.ang[k] = steer_angle(ys[k], xs[k]);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", checked, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 4);
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk_i) begin
    wheel_state_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ang = '{front_left_angle_o, front_right_angle_o, back_left_angle_o,
                  back_right_angle_o};
      got.spd = '{front_left_speed_o, front_right_speed_o, back_left_speed_o,
                  back_right_speed_o};
      if (pending_wheels.size() == 0) begin
        $display("result with no command waiting");
        errors++;
      end else begin
        want = pending_wheels.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got.ang[k] !== want.ang[k]) report_mismatch($sformatf("angle[%0d]", k),
                                                          got.ang[k], want.ang[k]);
          if (got.spd[k] !== want.spd[k]) report_mismatch($sformatf("speed[%0d]", k),
                                                          got.spd[k], want.spd[k]);
        end
      end
      checked++;
    end
  end

  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain_and_configure(logic [11:0] b, logic [11:0] t, logic [12:0] mx);
    in_valid_i <= 1'b0;
    wait (pending_wheels.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    apb_write({swk_pkg::REG_WHEEL_BASE, 2'b00}, {20'd0, b});
    apb_write({swk_pkg::REG_WHEEL_TRACK, 2'b00}, {20'd0, t});
    apb_write({swk_pkg::REG_MAX_SPEED, 2'b00}, {19'd0, mx});
    apb_write(ADDR_UNUSED, $urandom);
    cfg_base = b; cfg_track = t; cfg_max = mx;
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_cmd(cmd_row_t c);
    wheel_state_t w;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    forward_speed_i <= c.fwd; strafe_speed_i <= c.str; turn_rate_i <= c.turn;
    rot_center_x_i <= c.rcx; rot_center_y_i <= c.rcy;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    if (c.typed) begin
      w.ang = '{default: '0};
      w.spd = '{default: '0};
    end else begin
      w = wheel_states(c);
    end
    if (w.spd[0] < 13'd8191 && cfg_max != 0 && wheel_states(c).spd[0] == cfg_max) limited++;
    pending_wheels.push_back(w);
    sent++;
  endtask

  function automatic cmd_row_t random_cmd();
    cmd_row_t c;
    c.typed = 1'b0;
    case ($urandom_range(0, 9))
      0, 1: begin
        c.fwd = $urandom; c.str = $urandom; c.turn = $urandom;
        c.rcx = $urandom; c.rcy = $urandom;
      end
      2: begin
        c.fwd = $signed(14'($urandom_range(0, 200))) - 100;
        c.str = $signed(14'($urandom_range(0, 200))) - 100;
        c.turn = $signed(16'($urandom_range(0, 200))) - 100;
        c.rcx = 0; c.rcy = 0;
      end
      3: begin
        c.fwd = $urandom; c.str = 0; c.turn = 0; c.rcx = $urandom; c.rcy = $urandom;
      end
      default: begin
        c.fwd = $signed(14'($urandom_range(0, 16382))) - 8191;
        c.str = $signed(14'($urandom_range(0, 16382))) - 8191;
        c.turn = $signed(16'($urandom_range(0, 4000))) - 2000;
        c.rcx = $signed(12'($urandom_range(0, 1000))) - 500;
        c.rcy = $signed(12'($urandom_range(0, 1000))) - 500;
      end
    endcase
    return c;
  endfunction

  cmd_row_t directed [] = '{
    '{14'sd0, 14'sd0, 16'sd0, 12'sd0, 12'sd0, 1'b1},
    '{14'sd1000, 14'sd0, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{-14'sd1000, 14'sd0, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{14'sd0, 14'sd1000, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{14'sd0, -14'sd1000, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{14'sd0, 14'sd0, 16'sd1000, 12'sd0, 12'sd0, 1'b0},
    '{14'sd0, 14'sd0, -16'sd1000, 12'sd0, 12'sd0, 1'b0},
    '{14'sd8191, 14'sd0, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{-14'sd8192, 14'sd0, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{14'sd0, 14'sd8191, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{14'sd0, -14'sd8192, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{14'sd0, 14'sd0, 16'sd32767, 12'sd0, 12'sd0, 1'b0},
    '{14'sd0, 14'sd0, -16'sd32768, 12'sd0, 12'sd0, 1'b0},
    '{14'sd8191, 14'sd8191, 16'sd32767, 12'sd2047, 12'sd2047, 1'b0},
    '{-14'sd8192, -14'sd8192, -16'sd32768, -12'sd2048, -12'sd2048, 1'b0},
    '{14'sd500, -14'sd300, 16'sd2000, 12'sd2047, -12'sd2048, 1'b0},
    '{14'sd0, 14'sd0, 16'sd1500, 12'sd300, 12'sd300, 1'b0},
    '{-14'sd1, 14'sd0, 16'sd0, 12'sd0, 12'sd0, 1'b0},
    '{14'sd1, 14'sd1, 16'sd1, 12'sd1, 12'sd1, 1'b0},
    '{-14'sd1, -14'sd1, -16'sd1, -12'sd1, -12'sd1, 1'b0}
  };

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    foreach (directed[i]) send_cmd(directed[i]);
    drain_and_configure(12'd1, 12'd1, 13'd1);
    foreach (directed[i]) send_cmd(directed[i]);
    drain_and_configure(12'd4095, 12'd4095, 13'd8191);
    foreach (directed[i]) send_cmd(directed[i]);
    drain_and_configure(12'd600, 12'd600, 13'd0);
    foreach (directed[i]) send_cmd(directed[i]);
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_configure($urandom_range(1, 4095), $urandom_range(1, 4095),
                          ($urandom_range(0, 1) != 0) ? 13'($urandom_range(1, 8191))
                                                      : 13'($urandom_range(1, 600)));
      if (ph == 5) quiet = 1'b1;
      repeat (190) send_cmd(random_cmd());
    end
    in_valid_i <= 1'b0;
    wait (pending_wheels.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("sent %0d commands over ten register settings, %0d results checked, %0d limited",
             sent, checked, limited);
    $display("settings included unit and full-scale geometry and zero and low speed limits");
    if (errors == 0 && pending_wheels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
